### sv/gshd_pkg.sv
// Shared types, widths and offset tables for the Gregorian / Solar Hijri converter.
// Used by gshd_conv and by the top level gregorian_solar_hijri_date_converter.
package gshd_pkg;

  localparam int YEAR_IN_W  = 14;
  localparam int YEAR_OUT_W = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_IN_W   = 5;
  localparam int DAY_OUT_W  = 6;
  localparam int YY_W       = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Conversion direction carried in tuser
  localparam logic OP_G2SH = 1'b0;
  localparam logic OP_SH2G = 1'b1;

  // Split day / add-on day tables, rows in pairs, columns by month
  localparam logic [4:0] GREG_TAB [0:5][0:11] = '{
    '{5'd20, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20},
    '{5'd10, 5'd11, 5'd10, 5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10},
    '{5'd19, 5'd18, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd11, 5'd12, 5'd10, 5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9},
    '{5'd20, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
    '{5'd10, 5'd11, 5'd9,  5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9}
  };

  localparam logic [4:0] SH_TAB [0:5][0:11] = '{
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd9},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd11, 5'd10, 5'd10, 5'd9,  5'd9,  5'd9,  5'd8,  5'd9,  5'd9,  5'd10, 5'd11, 5'd10},
    '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
    '{5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9,  5'd10, 5'd10, 5'd11, 5'd12, 5'd10},
    '{5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd19, 5'd18}
  };

  // One accepted input word
  typedef struct packed {
    logic                   op;
    logic [YEAR_IN_W-1:0]   year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_IN_W-1:0]    day;
  } gshd_item_t;

  // One converted date
  typedef struct packed {
    logic [YEAR_OUT_W-1:0]  year;
    logic [MONTH_W-1:0]     month;
    logic [DAY_OUT_W-1:0]   day;
    logic                   is_sh;
  } gshd_res_t;

endpackage

### sv/gshd_conv.sv
// Combinational date conversion between the input and result registers.
// Depends on gshd_pkg for the item/result types and the offset tables.
module gshd_conv import gshd_pkg::*; (
  input  gshd_item_t item,
  output gshd_res_t  res
);

  logic [26:0]           prod;
  logic [6:0]            quo;
  logic [13:0]           quo_x100;
  logic [YY_W-1:0]       yy;
  logic [1:0]            q;
  logic [MONTH_W-1:0]    mc;
  logic [MONTH_W-1:0]    mi;
  logic [2:0]            row;
  logic [2:0]            row_add;
  logic [4:0]            split;
  logic [4:0]            addon;
  logic                  le;
  logic [YY_W-1:0]       yy_g;
  logic [YY_W-1:0]       yy_lo;
  logic [YEAR_OUT_W-1:0] year;
  logic [MONTH_W-1:0]    month;
  logic [DAY_OUT_W-1:0]  day;

  // Year mod 100 through a reciprocal multiply (exact below 10000)
  assign prod     = 27'(item.year) * 27'd5243;
  assign quo      = prod[25:19];
  assign quo_x100 = 14'(quo) * 14'd100;
  assign yy       = YY_W'(item.year - quo_x100);
  assign q        = yy[1:0];

  // Clamp month to 1..12
  always_comb begin
    if (item.month == 4'd0) begin
      mc = 4'd1;
    end else if (item.month > 4'd12) begin
      mc = 4'd12;
    end else begin
      mc = item.month;
    end
  end
  assign mi = mc - 4'd1;

  // Pick the table row pair
  always_comb begin
    if (item.op == OP_G2SH) begin
      row = (q == 2'd3) ? 3'd4 : {q, 1'b0};
    end else begin
      row = (q == 2'd0) ? 3'd0 : {q - 2'd1, 1'b0};
    end
  end
  assign row_add = row + 3'd1;

  always_comb begin
    if (item.op == OP_G2SH) begin
      split = GREG_TAB[row][mi];
      addon = GREG_TAB[row_add][mi];
    end else begin
      split = SH_TAB[row][mi];
      addon = SH_TAB[row_add][mi];
    end
  end

  assign le  = ({1'b0, item.day} <= {1'b0, split});
  assign day = le ? (DAY_OUT_W'(item.day) + DAY_OUT_W'(addon))
                  : (DAY_OUT_W'(item.day) - DAY_OUT_W'(split));

  // Shift month and rebuild the year
  always_comb begin
    yy_g = '0;
    if (item.op == OP_G2SH) begin
      if (mc < 4'd3 || (mc == 4'd3 && le)) begin
        year = YEAR_OUT_W'(yy) + 12'd1378;
      end else begin
        year = YEAR_OUT_W'(yy) + 12'd1379;
      end
      if (le) begin
        month = (mc <= 4'd3) ? mc + 4'd9 : mc - 4'd3;
      end else begin
        month = (mc <= 4'd2) ? mc + 4'd10 : mc - 4'd2;
      end
    end else begin
      if (mc < 4'd10 || (mc == 4'd10 && le)) begin
        yy_g = (yy >= 7'd79) ? yy - 7'd79 : yy + 7'd21;
      end else begin
        yy_g = (yy >= 7'd78) ? yy - 7'd78 : yy + 7'd22;
      end
      year = (yy_g < 7'd70) ? YEAR_OUT_W'(yy_g) + 12'd2000
                            : YEAR_OUT_W'(yy_g) + 12'd1900;
      if (le) begin
        month = (mc <= 4'd10) ? mc + 4'd2 : mc - 4'd10;
      end else begin
        month = (mc <= 4'd9) ? mc + 4'd3 : mc - 4'd9;
      end
    end
  end
  assign yy_lo = yy_g;

  assign res.year  = year;
  assign res.month = month;
  assign res.day   = day;
  assign res.is_sh = (item.op == OP_G2SH) && (yy_lo == yy_g);

endmodule

### sv/gregorian_solar_hijri_date_converter.sv
// Top level: input register, conversion logic, output register with stream handshake.
// Depends on gshd_pkg and gshd_conv.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  in_     | slave     | year[13:0], month[17:14], day[22:18], pad   | operation
//  out_    | master    | year[11:0], month[15:12], day[21:16], pad   | is_solar_hijri
//
// One word per cycle while out_tready is high; input register, then result register.
// The conversion is one table lookup plus a reciprocal multiply for the year mod 100.
// Synchronous active-low reset clears both valid flags; payload registers are not reset.
// A stalled output holds its word; the input register keeps filling while the result
// register is free, and in_tready drops only when both stages are full and out_tready is low.
module gregorian_solar_hijri_date_converter import gshd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // in_year, in_month, in_day
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_year, out_month, out_day
  output logic                  out_tuser   // is_solar_hijri
);

  gshd_item_t item_r, item_nxt;
  logic       s1_vld_r, s1_vld_nxt;
  gshd_res_t  res;
  gshd_res_t  res_r, res_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       adv;
  logic       in_acc;

  // Stage handshakes
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Next state of both stages
  always_comb begin
    item_nxt    = item_r;
    s1_vld_nxt  = s1_vld_r;
    res_nxt     = res_r;
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = s1_vld_r;
      if (s1_vld_r) begin
        res_nxt = res;
      end
    end
    if (in_tready) begin
      s1_vld_nxt = in_tvalid;
      if (in_tvalid) begin
        item_nxt.op    = in_tuser;
        item_nxt.year  = in_tdata[13:0];
        item_nxt.month = in_tdata[17:14];
        item_nxt.day   = in_tdata[22:18];
      end
    end
  end

  // Hold valid flags under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

  gshd_conv u_conv (
    .item (item_r),
    .res  (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r.day, res_r.month, res_r.year};
  assign out_tuser  = res_r.is_sh;

  // Accepted word lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted word not captured");

  // Converted month always in 1..12
  a_month_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (res_r.month >= 4'd1 && res_r.month <= 4'd12))
    else $error("month out of range");

  // Solar Hijri year window
  a_sh_year: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.is_sh) |-> (res_r.year >= 12'd1378 && res_r.year <= 12'd1478))
    else $error("solar hijri year out of window");

  // Gregorian year window
  a_g_year: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.is_sh) |-> (res_r.year >= 12'd1970 && res_r.year <= 12'd2069))
    else $error("gregorian year out of window");

  // A full input stage moves on whenever the result register frees up
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && adv) |=> out_vld_r)
    else $error("input stage did not advance");

endmodule

### verif/tb_top.sv
// Self-checking testbench for gregorian_solar_hijri_date_converter: directed and random dates
// in both directions, checked word by word against a local offset-table predictor.
// Depends on gshd_pkg for the operation codes and the stream widths.
`timescale 1ns / 100ps

module tb_top;
  import gshd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Split day / add-on day, rows in pairs, one column per month
  localparam int GREG_OFS [0:5][0:11] = '{
    '{20, 19, 19, 19, 20, 20, 21, 21, 21, 21, 20, 20},
    '{10, 11, 10, 12, 11, 11, 10, 10, 10,  9, 10, 10},
    '{19, 18, 20, 20, 21, 21, 22, 22, 22, 22, 21, 21},
    '{11, 12, 10, 11, 10, 10,  9,  9,  9,  8,  9,  9},
    '{20, 19, 20, 20, 21, 21, 22, 22, 22, 22, 21, 21},
    '{10, 11,  9, 11, 10, 10,  9,  9,  9,  8,  9,  9}
  };

  localparam int PERSIAN_OFS [0:5][0:11] = '{
    '{11, 10, 10,  9,  9,  9,  8,  9,  9, 10, 11,  9},
    '{20, 20, 21, 21, 22, 22, 22, 22, 21, 21, 20, 19},
    '{11, 10, 10,  9,  9,  9,  8,  9,  9, 10, 11, 10},
    '{20, 20, 21, 21, 22, 22, 22, 22, 21, 21, 20, 19},
    '{12, 11, 11, 10, 10, 10,  9, 10, 10, 11, 12, 10},
    '{19, 19, 20, 20, 21, 21, 21, 21, 20, 20, 19, 18}
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [5:0]  day;
    logic        is_sh;
  } conv_date_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // in_year, in_month, in_day
  logic                  in_tuser = 1'b0; // operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // out_year, out_month, out_day
  logic                  out_tuser;       // is_solar_hijri

  conv_date_t pending_dates [$];
  int         mismatch_cnt = 0;
  int         stall_cycles = 0;
  bit         no_idle = 1'b0;

  gregorian_solar_hijri_date_converter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Predict the converted date for one input word
  function automatic conv_date_t convert_date(logic op, logic [13:0] yr, logic [3:0] mo,
                                              logic [4:0] dy);
    int yy, q, m, d, row, split, addon, y, mon, day;
    conv_date_t r;
    yy = int'(yr) % 100;
    q  = yy % 4;
    m  = int'(mo);
    d  = int'(dy);
    // clamp out-of-range months to the table edges
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (op == OP_G2SH) begin
      row   = (q == 3) ? 4 : q * 2;
      split = GREG_OFS[row][m-1];
      addon = GREG_OFS[row+1][m-1];
      y = (m < 3 || (m == 3 && d <= split)) ? yy + 78 : yy + 79;
      y = y + 1300;
      mon = (d <= split) ? (m + 8) % 12 + 1 : (m + 9) % 12 + 1;
    end else begin
      row   = (q == 0) ? 0 : (q - 1) * 2;
      split = PERSIAN_OFS[row][m-1];
      addon = PERSIAN_OFS[row+1][m-1];
      if (m < 10 || (m == 10 && d <= split))
        y = (yy >= 79) ? yy - 79 : yy + 21;
      else
        y = (yy >= 78) ? yy - 78 : yy + 22;
      y = y + ((y < 70) ? 2000 : 1900);
      mon = (d <= split) ? (m + 1) % 12 + 1 : (m + 2) % 12 + 1;
    end
    day = (d <= split) ? d + addon : d - split;
    r.year  = 12'(y);
    r.month = 4'(mon);
    r.day   = 6'(day);
    r.is_sh = (op == OP_G2SH);
    return r;
  endfunction

  // Drive one date word, sometimes after a random gap unless no_idle is set, and hold it until accepted
  task automatic send_date(logic op, logic [13:0] yr, logic [3:0] mo, logic [4:0] dy);
    if (!no_idle && $urandom_range(99) < 27) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 27) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, dy, mo, yr};
    do @(posedge clk); while (!in_tready);
  endtask

  // Receiver stalls at random unless the stream is running steady
  always @(posedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
  end

  // Record predictions on input words, check result words against the oldest one
  always @(posedge clk) begin
    conv_date_t exp_d, got;
    bit bad;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        pending_dates.push_back(convert_date(in_tuser, in_tdata[13:0], in_tdata[17:14],
                                             in_tdata[22:18]));
      if (out_tvalid && out_tready) begin
        got.year  = out_tdata[11:0];
        got.month = out_tdata[15:12];
        got.day   = out_tdata[21:16];
        got.is_sh = out_tuser;
        if (pending_dates.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result word: year %0d month %0d day %0d sh %0d",
                     got.year, got.month, got.day, got.is_sh);
        end else begin
          exp_d = pending_dates.pop_front();
          bad = (got.year != exp_d.year) || (got.month != exp_d.month) ||
                (got.day != exp_d.day) || (got.is_sh != exp_d.is_sh);
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("mismatch: expected %0d-%0d-%0d sh %0d, got %0d-%0d-%0d sh %0d",
                       exp_d.year, exp_d.month, exp_d.day, exp_d.is_sh,
                       got.year, got.month, got.day, got.is_sh);
          end
        end
      end
    end
  end

  // Abort when neither side moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // All-zero year bits, all-one year bits in both directions, extreme months and days
  task automatic test_field_extremes();
    send_date(OP_G2SH, 14'd0, 4'd1, 5'd1);
    send_date(OP_SH2G, 14'd16383, 4'd12, 5'd31);
    send_date(OP_G2SH, 14'd9999, 4'd12, 5'd31);
    send_date(OP_SH2G, 14'd99, 4'd1, 5'd1);
    send_date(OP_G2SH, 14'd16383, 4'd15, 5'd31);
  endtask

  // Month zero reads as January, 13..15 as December
  task automatic test_month_clamp();
    send_date(OP_G2SH, 14'd2024, 4'd0, 5'd5);
    send_date(OP_SH2G, 14'd1403, 4'd0, 5'd25);
    send_date(OP_G2SH, 14'd2023, 4'd13, 5'd25);
    send_date(OP_SH2G, 14'd1402, 4'd14, 5'd3);
  endtask

  // Days on each side of the split day, and day zero taking the add-on day
  task automatic test_split_days();
    send_date(OP_G2SH, 14'd2021, 4'd3, 5'd20);
    send_date(OP_G2SH, 14'd2021, 4'd3, 5'd21);
    send_date(OP_SH2G, 14'd1400, 4'd10, 5'd10);
    send_date(OP_SH2G, 14'd1400, 4'd10, 5'd11);
    send_date(OP_G2SH, 14'd2022, 4'd7, 5'd0);
    send_date(OP_SH2G, 14'd1401, 4'd4, 5'd0);
  endtask

  // Century rebuild: the 78/79 wrap and the 1900/2000 boundary at two-digit year 70
  task automatic test_century_windows();
    send_date(OP_SH2G, 14'd1378, 4'd10, 5'd31);
    send_date(OP_SH2G, 14'd1379, 4'd1, 5'd1);
    send_date(OP_SH2G, 14'd1348, 4'd6, 5'd15);
    send_date(OP_SH2G, 14'd1349, 4'd6, 5'd15);
    send_date(OP_SH2G, 14'd1377, 4'd11, 5'd2);
    send_date(OP_G2SH, 14'd2099, 4'd12, 5'd30);
  endtask

  // Random dates: mostly valid fields, some years past 9999, odd months and day zero
  task automatic test_random_dates(int count);
    logic [13:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    for (int i = 0; i < count; i++) begin
      yr = ($urandom_range(9) == 0) ? 14'($urandom_range(16383)) : 14'($urandom_range(9999));
      mo = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12, 1));
      dy = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(31, 1));
      send_date(logic'($urandom_range(1)), yr, mo, dy);
    end
  endtask

  // Back-to-back words with both sides always ready
  task automatic test_steady_stream(int count);
    no_idle = 1'b1;
    test_random_dates(count);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_month_clamp();
    test_split_days();
    test_century_windows();
    test_random_dates(500);
    test_steady_stream(300);
    test_random_dates(400);
    in_tvalid <= 1'b0;
    // drain outstanding results, then allow the pipeline latency
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && pending_dates.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### gregorian_solar_hijri_date_converter.f
sv/gshd_pkg.sv
sv/gshd_conv.sv
sv/gregorian_solar_hijri_date_converter.sv
verif/tb_top.sv
